// ----- sv/bdil_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdil_pkg
// Shared constants, register indexes and types of the 3x3 binary dilation.
// ----------------------------------------------------------------------------
package bdil_pkg;

	localparam int FRAME_HEIGHT = 16;
	localparam int FRAME_WIDTH  = 16;

	localparam int ROW_W = $clog2(FRAME_HEIGHT);
	localparam int COL_W = $clog2(FRAME_WIDTH);

	localparam int PIX_W     = 8;
	localparam int POS_W     = 4;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;

	localparam int SLOTS   = 4;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int COUNT_W = $clog2(SLOTS + 1);

	localparam logic [CFG_IDX_W-1:0] REG_SEED_LEVEL = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE = CFG_IDX_W'(1);

	localparam logic [PIX_W-1:0] SEED_LEVEL_RST = 8'hFF;
	localparam logic [PIX_W-1:0] FILL_VALUE_RST = 8'hFF;

	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FRAME_HEIGHT - 1);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_WIDTH - 1);

	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
	} lb_rd_t;

	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
		logic             seed;
		logic             first_row;
	} lb_wr_t;

	typedef struct packed {
		logic three_rows;
		logic two_rows;
	} lb_col_t;

	typedef struct packed {
		logic             hit;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} res_slot_t;

endpackage

// ----- sv/bdil_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdil_pix_if / bdil_res_if
// Valid/ready channels for the input pixels and the dilated result pixels.
// ----------------------------------------------------------------------------
interface bdil_pix_if;
	logic                     valid;
	logic                     ready;
	logic [bdil_pkg::PIX_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface bdil_res_if;
	logic                       valid;
	logic                       ready;
	logic [bdil_pkg::PIX_W-1:0] out_pixel;
	logic [bdil_pkg::POS_W-1:0] out_row;
	logic [bdil_pkg::POS_W-1:0] out_col;
	logic                       frame_last;

	modport source (output valid, output out_pixel, output out_row, output out_col,
		output frame_last, input ready);
	modport sink   (input valid, input out_pixel, input out_row, input out_col,
		input frame_last, output ready);
endinterface

// ----- sv/bdil_line_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdil_line_buf
// Line memory holding the seed bits of the two previous rows per column.
// Read-modify-write: the entry read for a column is shifted by one row and
// written back with the current seed bit; column ORs feed the window.
// ----------------------------------------------------------------------------
module bdil_line_buf (
	input  logic              clk,
	input  bdil_pkg::lb_rd_t  rd,
	input  bdil_pkg::lb_wr_t  wr,
	output bdil_pkg::lb_col_t col
);

	// bit 0: row above, bit 1: two rows above
	logic [1:0] line_mem [bdil_pkg::FRAME_WIDTH];
	logic [1:0] rd_data_s1;
	logic       up1;
	logic       up2;

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_s1 <= line_mem[rd.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			line_mem[wr.addr] <= {up1, wr.seed};
		end
	end

	// drop stale rows at the top of the frame
	assign up1 = rd_data_s1[0] & ~wr.first_row;
	assign up2 = rd_data_s1[1] & ~wr.first_row;

	assign col.three_rows = wr.seed | up1 | up2;
	assign col.two_rows   = wr.seed | up1;

endmodule

// ----- sv/binary_dilation_3x3.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_dilation_3x3
// Streaming 3x3 binary dilation over a fixed raster-order frame.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle unless the result register holds it back. A
// frame of H x W pixels yields (H-1)*(W-1) + (H-1) + (W-1) + 1 results.
// The input stalls only while the result register drains the extra
// results of a row's last column (two results), of the last row (two) and
// of the frame's last pixel (four), or while backpressure holds the output.
// A result passes the line memory read stage and then the result register.
// The line memory is read and rewritten once per pixel; no clearing pass is
// needed, the first row of each frame masks it.
// ----------------------------------------------------------------------------
module binary_dilation_3x3 (
	input  logic                           clk,
	input  logic                           arst_n,
	bdil_pix_if.sink                       pixels,
	bdil_res_if.source                     results,
	input  logic                           cfg_we,
	input  logic [bdil_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bdil_pkg::CFG_W-1:0]     cfg_wdata
);

	logic [bdil_pkg::PIX_W-1:0] seed_level_q;
	logic [bdil_pkg::PIX_W-1:0] fill_value_q;

	logic [bdil_pkg::ROW_W-1:0] row_q;
	logic [bdil_pkg::COL_W-1:0] col_q;
	logic                       pix_acc;
	logic                       interior;

	logic                       s1_valid_q;
	logic [bdil_pkg::ROW_W-1:0] row_s1;
	logic [bdil_pkg::COL_W-1:0] col_s1;
	logic                       seed_s1;
	logic                       s1_adv;

	bdil_pkg::lb_rd_t  lb_rd;
	bdil_pkg::lb_wr_t  lb_wr;
	bdil_pkg::lb_col_t lb_col;

	logic wa1_q, wa2_q, wb1_q, wb2_q;
	logic c_ge2, c_last, r_last;
	logic hit_a0, hit_a1, hit_b0, hit_b1;
	logic [bdil_pkg::ROW_W-1:0] row_m1;
	logic [bdil_pkg::COL_W-1:0] col_m1;
	bdil_pkg::res_slot_t        slot_d [bdil_pkg::SLOTS];
	logic [bdil_pkg::COUNT_W-1:0] n_d;

	logic                        s2_valid_q;
	bdil_pkg::res_slot_t         slot_s2 [bdil_pkg::SLOTS];
	logic [bdil_pkg::SLOT_W-1:0] last_idx_s2;
	logic [bdil_pkg::SLOT_W-1:0] k_q;
	logic                        out_acc;
	logic                        s2_free;
	bdil_pkg::res_slot_t         cur;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_level_q <= bdil_pkg::SEED_LEVEL_RST;
			fill_value_q <= bdil_pkg::FILL_VALUE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdil_pkg::REG_SEED_LEVEL: seed_level_q <= cfg_wdata;
				bdil_pkg::REG_FILL_VALUE: fill_value_q <= cfg_wdata;
			endcase
		end
	end

	// input side: raster position and seed detection
	assign pix_acc      = pixels.valid & pixels.ready;
	assign pixels.ready = ~s1_valid_q | s1_adv;
	assign interior     = (row_q != '0) && (row_q != bdil_pkg::ROW_LAST) &&
	                      (col_q != '0) && (col_q != bdil_pkg::COL_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (pix_acc) begin
			if (col_q == bdil_pkg::COL_LAST) begin
				col_q <= '0;
				row_q <= (row_q == bdil_pkg::ROW_LAST) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pixels.ready) begin
			s1_valid_q <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			row_s1  <= row_q;
			col_s1  <= col_q;
			seed_s1 <= interior && (pixels.pixel == seed_level_q);
		end
	end

	// line memory
	assign lb_rd.en        = pix_acc;
	assign lb_rd.addr      = col_q;
	assign lb_wr.en        = s1_adv;
	assign lb_wr.addr      = col_s1;
	assign lb_wr.seed      = seed_s1;
	assign lb_wr.first_row = (row_s1 == '0);

	bdil_line_buf u_line_buf (
		.clk (clk),
		.rd  (lb_rd),
		.wr  (lb_wr),
		.col (lb_col)
	);

	// horizontal window over the column ORs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wa1_q <= 1'b0;
			wa2_q <= 1'b0;
			wb1_q <= 1'b0;
			wb2_q <= 1'b0;
		end else if (s1_adv) begin
			wa1_q <= lb_col.three_rows;
			wa2_q <= wa1_q;
			wb1_q <= lb_col.two_rows;
			wb2_q <= wb1_q;
		end
	end

	assign c_ge2  = (col_s1 > bdil_pkg::COL_W'(1));
	assign c_last = (col_s1 == bdil_pkg::COL_LAST);
	assign r_last = (row_s1 == bdil_pkg::ROW_LAST);
	assign row_m1 = row_s1 - 1'b1;
	assign col_m1 = col_s1 - 1'b1;

	assign hit_a0 = lb_col.three_rows | wa1_q | (wa2_q & c_ge2);
	assign hit_a1 = lb_col.three_rows | wa1_q;
	assign hit_b0 = lb_col.two_rows | wb1_q | (wb2_q & c_ge2);
	assign hit_b1 = lb_col.two_rows | wb1_q;

	// results of this pixel in emission order
	always_comb begin
		bdil_pkg::res_slot_t a0, a1, b0, b1;
		a0 = '{hit: hit_a0, row: row_m1, col: col_m1, last: 1'b0};
		a1 = '{hit: hit_a1, row: row_m1, col: col_s1, last: 1'b0};
		b0 = '{hit: hit_b0, row: row_s1, col: col_m1, last: 1'b0};
		b1 = '{hit: hit_b1, row: row_s1, col: col_s1, last: 1'b1};
		slot_d[0] = a0;
		slot_d[1] = b0;
		slot_d[2] = b0;
		slot_d[3] = b1;
		n_d       = '0;
		if ((row_s1 != '0) && (col_s1 != '0)) begin
			if (c_last) begin
				slot_d[1] = a1;
				n_d = r_last ? bdil_pkg::COUNT_W'(4) : bdil_pkg::COUNT_W'(2);
			end else begin
				n_d = r_last ? bdil_pkg::COUNT_W'(2) : bdil_pkg::COUNT_W'(1);
			end
		end
	end

	// result register
	assign out_acc = results.valid & results.ready;
	assign s2_free = ~s2_valid_q | (results.ready & (k_q == last_idx_s2));
	assign s1_adv  = s1_valid_q & ((n_d == '0) | s2_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			k_q        <= '0;
		end else if (s1_adv && (n_d != '0)) begin
			s2_valid_q <= 1'b1;
			k_q        <= '0;
		end else if (out_acc) begin
			if (k_q == last_idx_s2) begin
				s2_valid_q <= 1'b0;
			end else begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && (n_d != '0)) begin
			slot_s2     <= slot_d;
			last_idx_s2 <= bdil_pkg::SLOT_W'(n_d - 1'b1);
		end
	end

	assign cur                = slot_s2[k_q];
	assign results.valid      = s2_valid_q;
	assign results.out_pixel  = cur.hit ? fill_value_q : '0;
	assign results.out_row    = bdil_pkg::POS_W'(cur.row);
	assign results.out_col    = bdil_pkg::POS_W'(cur.col);
	assign results.frame_last = cur.last;

endmodule

// ----- sv/bdil_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdil_checker
// Port-level checks of the 3x3 binary dilation: result values against the
// fill register, frame_last on the frame's corner pixel, and output hold
// under backpressure.
// ----------------------------------------------------------------------------
module bdil_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic [bdil_pkg::PIX_W-1:0]     out_pixel,
	input logic [bdil_pkg::POS_W-1:0]     out_row,
	input logic [bdil_pkg::POS_W-1:0]     out_col,
	input logic                           frame_last,
	input logic                           cfg_we,
	input logic [bdil_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [bdil_pkg::CFG_W-1:0]     cfg_wdata
);

	logic [bdil_pkg::PIX_W-1:0] fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= bdil_pkg::FILL_VALUE_RST;
		end else if (cfg_we && (cfg_index == bdil_pkg::REG_FILL_VALUE)) begin
			fill_q <= cfg_wdata;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid &&
		$stable({out_pixel, out_row, out_col, frame_last}))
		else $error("result changed while stalled");

	a_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (out_pixel == '0) || (out_pixel == fill_q))
		else $error("result pixel is neither zero nor the fill value");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (frame_last ==
		((out_row == bdil_pkg::POS_W'(bdil_pkg::ROW_LAST)) &&
		(out_col == bdil_pkg::POS_W'(bdil_pkg::COL_LAST)))))
		else $error("frame_last on wrong result");

endmodule

bind binary_dilation_3x3 bdil_checker u_bdil_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.out_pixel  (results.out_pixel),
	.out_row    (results.out_row),
	.out_col    (results.out_col),
	.frame_last (results.frame_last),
	.cfg_we     (cfg_we),
	.cfg_index  (cfg_index),
	.cfg_wdata  (cfg_wdata)
);
